/* sv/spgr_pkg.sv */
// Shared types and constants for the sequenced packet gap recovery block.
package spgr_pkg;

  // Fixed header sizes in bytes
  localparam logic [15:0] HEADER_BYTES         = 16'd20;
  localparam logic [15:0] MESSAGE_HEADER_BYTES = 16'd2;

  // End-of-session marker in the header message count
  localparam logic [15:0] COUNT_SESSION_END = 16'hFFFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_INITIAL_SEQUENCE  = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS     = 2'd1;
  localparam logic [1:0] CFG_MAX_REQUEST_COUNT = 2'd2;

  // Configuration reset values
  localparam logic [63:0] INITIAL_SEQUENCE_RST  = 64'd0;
  localparam logic [31:0] TIMEOUT_TICKS_RST     = 32'd1000;
  localparam logic [15:0] MAX_REQUEST_COUNT_RST = 16'd65534;

  // Error codes
  localparam logic [1:0] ERR_OK               = 2'd0;
  localparam logic [1:0] ERR_HEADER_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_BLOCK_TRUNCATED  = 2'd2;

  typedef enum logic [1:0] {
    MODE_COLD  = 2'd0,
    MODE_SYNC  = 2'd1,
    MODE_RECOV = 2'd2
  } mode_e;

  // One parsed packet header
  typedef struct packed {
    logic [63:0] pkt_sequence;
    logic [15:0] msg_count;
    logic [15:0] packet_length;
    logic [15:0] first_message_length;
    logic [47:0] current_time;
  } item_t;

  // Sequencing state carried from packet to packet
  typedef struct packed {
    logic [63:0] expected_sequence;
    mode_e       recovery_mode;
    logic [63:0] window_end;
    logic [47:0] last_request_time;
  } state_t;

  // One result transaction
  typedef struct packed {
    logic        delivered;
    logic [15:0] message_length;
    logic        request_valid;
    logic [63:0] request_sequence;
    logic [15:0] request_count;
    logic        session_end;
    logic [1:0]  error_code;
  } result_t;

endpackage

/* sv/spgr_in_reg.sv */
// Input register stage: holds one accepted header until the core takes it.
module spgr_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spgr_pkg::item_t item_i,
  input  logic           take_i,
  output logic           valid_o,
  output spgr_pkg::item_t item_o
);
  import spgr_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // Free slot, or the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* sv/spgr_core.sv */
// Per-packet sequencing logic: gap detection, requests, delivery checks.
module spgr_core (
  input  spgr_pkg::item_t   item_i,
  input  spgr_pkg::state_t  state_i,
  input  logic [31:0]       timeout_ticks_i,
  input  logic [15:0]       max_request_count_i,
  output spgr_pkg::state_t  state_o,
  output spgr_pkg::result_t result_o
);
  import spgr_pkg::*;

  logic        eos;
  logic [15:0] count_eff;
  logic [63:0] next_seq;
  logic [63:0] exp_seq;
  logic        seq_ahead;
  logic        seq_match;
  logic [47:0] elapsed;
  logic        timed_out;
  logic [16:0] block_need;
  logic        block_fits;
  logic        req;
  logic [63:0] req_start;
  logic [63:0] remaining;

  assign eos       = item_i.msg_count == COUNT_SESSION_END;
  assign count_eff = eos ? 16'd0 : item_i.msg_count;
  assign next_seq  = item_i.pkt_sequence + {48'd0, count_eff};

  // Expected zero means adopt this packet's sequence
  assign exp_seq   = (state_i.expected_sequence == 64'd0) ? item_i.pkt_sequence
                                                          : state_i.expected_sequence;
  assign seq_ahead = item_i.pkt_sequence > exp_seq;
  assign seq_match = item_i.pkt_sequence == exp_seq;

  // 48-bit subtract wraps naturally
  assign elapsed   = item_i.current_time - state_i.last_request_time;
  assign timed_out = elapsed > {16'd0, timeout_ticks_i};

  assign block_need = {1'b0, HEADER_BYTES} + {1'b0, MESSAGE_HEADER_BYTES}
                    + {1'b0, item_i.first_message_length};
  assign block_fits = block_need <= {1'b0, item_i.packet_length};

  always_comb begin
    state_o   = state_i;
    result_o  = '0;
    req       = 1'b0;
    req_start = exp_seq;
    remaining = 64'd0;

    if (item_i.packet_length < HEADER_BYTES) begin
      result_o.error_code = ERR_HEADER_TRUNCATED;
    end else begin
      result_o.session_end      = eos;
      state_o.expected_sequence = exp_seq;

      if (seq_ahead) begin
        case (state_i.recovery_mode)
          MODE_COLD, MODE_SYNC: begin
            state_o.window_end    = next_seq;
            state_o.recovery_mode = MODE_RECOV;
            req                   = 1'b1;
          end
          default: begin
            // recovering: widen window, resend only after timeout
            if (next_seq > state_i.window_end) begin
              state_o.window_end = next_seq;
            end
            req = timed_out;
          end
        endcase
      end else if (seq_match) begin
        case (state_i.recovery_mode)
          MODE_COLD: begin
            state_o.recovery_mode = MODE_SYNC;
          end
          MODE_SYNC: begin
            state_o.recovery_mode = MODE_SYNC;
          end
          default: begin
            if (state_i.window_end == next_seq) begin
              state_o.recovery_mode = MODE_SYNC;
            end else begin
              req       = 1'b1;
              req_start = next_seq;
            end
          end
        endcase
        if (!eos) begin
          if (block_fits) begin
            result_o.delivered        = 1'b1;
            result_o.message_length   = item_i.first_message_length;
            state_o.expected_sequence = exp_seq + 64'd1;
          end else begin
            result_o.error_code = ERR_BLOCK_TRUNCATED;
          end
        end
      end

      // Count wraps huge when window lies below start, then clamps
      remaining = state_o.window_end - req_start;
      if (req) begin
        result_o.request_valid    = 1'b1;
        result_o.request_sequence = req_start;
        result_o.request_count    = (remaining < {48'd0, max_request_count_i})
                                    ? remaining[15:0] : max_request_count_i;
        state_o.last_request_time = item_i.current_time;
      end
    end
  end

endmodule

/* sv/sequenced_packet_gap_recovery.sv */
// Top level of the sequenced packet gap recovery block.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------------
//   input    | in_valid_i / in_ready_o   | pkt_sequence .. current_time
//   result   | out_valid_o / out_ready_i | delivered .. error_code
//   config   | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// The header sits in the input register while the sequencing logic works on it,
// and the result register loads from the core when the core fires. One
// transaction per cycle is sustained while the result channel is not stalled;
// the sequencing state is updated at the same edge the result register loads,
// so the next header sees it. A stalled result register holds the core; the
// input register still takes one more transaction. Reset clears valids, mode
// and sequencing state.
module sequenced_packet_gap_recovery (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] pkt_sequence_i,
  input  logic [15:0] msg_count_i,
  input  logic [15:0] packet_length_i,
  input  logic [15:0] first_message_length_i,
  input  logic [47:0] current_time_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        delivered_o,
  output logic [15:0] message_length_o,
  output logic        request_valid_o,
  output logic [63:0] request_sequence_o,
  output logic [15:0] request_count_o,
  output logic        session_end_o,
  output logic [1:0]  error_code_o
);
  import spgr_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;

  state_t  state_q, state_d;
  result_t core_result;
  result_t result_q;
  logic    out_valid_q, out_valid_d;

  logic [31:0] timeout_ticks_q;
  logic [15:0] max_request_count_q;

  assign in_item.pkt_sequence         = pkt_sequence_i;
  assign in_item.msg_count            = msg_count_i;
  assign in_item.packet_length        = packet_length_i;
  assign in_item.first_message_length = first_message_length_i;
  assign in_item.current_time         = current_time_i;

  // Core fires when a header is held and the result register is free or draining
  assign advance = held_valid && (!out_valid_q || out_ready_i);

  spgr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  spgr_core u_core (
    .item_i              (held_item),
    .state_i             (state_q),
    .timeout_ticks_i     (timeout_ticks_q),
    .max_request_count_i (max_request_count_q),
    .state_o             (state_d),
    .result_o            (core_result)
  );

  // Config registers; initial_sequence goes straight into expected_sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q     <= TIMEOUT_TICKS_RST;
      max_request_count_q <= MAX_REQUEST_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TIMEOUT_TICKS:     timeout_ticks_q     <= cfg_data_i[31:0];
        CFG_MAX_REQUEST_COUNT: max_request_count_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Sequencing state: the user must write config only while idle; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.expected_sequence <= INITIAL_SEQUENCE_RST;
      state_q.recovery_mode     <= MODE_COLD;
      state_q.window_end        <= 64'd0;
      state_q.last_request_time <= 48'd0;
    end else if (cfg_we_i && (cfg_index_i == CFG_INITIAL_SEQUENCE)) begin
      state_q.expected_sequence <= cfg_data_i;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= core_result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign delivered_o        = result_q.delivered;
  assign message_length_o   = result_q.message_length;
  assign request_valid_o    = result_q.request_valid;
  assign request_sequence_o = result_q.request_sequence;
  assign request_count_o    = result_q.request_count;
  assign session_end_o      = result_q.session_end;
  assign error_code_o       = result_q.error_code;

  // A delivery is always clean and never at end of session
  a_deliver_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && delivered_o |-> (error_code_o == ERR_OK) && !session_end_o)
    else $error("delivery with error or end of session");

  // A truncated header produces nothing else
  a_header_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o == ERR_HEADER_TRUNCATED)
      |-> !delivered_o && !request_valid_o && !session_end_o)
    else $error("header-truncated result carries other flags");

  // Request count never exceeds the configured cap
  a_req_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && request_valid_o |-> request_count_o <= max_request_count_q)
    else $error("request count above cap");

  // Delivery moves the expected sequence one past the delivered packet
  a_deliver_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && core_result.delivered
      |=> state_q.expected_sequence == ($past(held_item.pkt_sequence) + 64'd1))
    else $error("expected sequence not advanced after delivery");

endmodule
